FILE: src/bds2x2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds2x2_pkg
// Shared types and constants of the 2x2 box downscaler for RGB streams.
// ----------------------------------------------------------------------------
package bds2x2_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int PAIR_CH_W    = 9;
    localparam int PAIR_W       = 3 * PAIR_CH_W;
    localparam int IN_WIDTH_W   = 13;
    localparam int OUT_WIDTH_W  = 12;
    localparam int OUT_HEIGHT_W = 12;
    localparam int COUNT_W      = 12;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;

    localparam int MAX_OUT_WIDTH_DEF = 2048;

    localparam logic [IN_WIDTH_W-1:0]   IN_WIDTH_RST   = 13'd640;
    localparam logic [OUT_WIDTH_W-1:0]  OUT_WIDTH_RST  = 12'd320;
    localparam logic [OUT_HEIGHT_W-1:0] OUT_HEIGHT_RST = 12'd240;

    localparam logic [IN_WIDTH_W-1:0]   STRIDE_MIN   = 13'd2;
    localparam logic [IN_WIDTH_W-1:0]   STRIDE_MAX   = 13'd4096;
    localparam logic [OUT_HEIGHT_W-1:0] OUT_ROWS_MAX = 12'd2048;
    localparam logic [COUNT_W-1:0]      ROW_MAX      = 12'd4095;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IN_WIDTH   = 2'd0,
        REG_OUT_WIDTH  = 2'd1,
        REG_OUT_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } line_req_t;

endpackage

FILE: src/bds2x2_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds2x2_line_store
// Line memory of even-row pair sums, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module bds2x2_line_store #(
    parameter int DEPTH = bds2x2_pkg::MAX_OUT_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          aclk,
    input  bds2x2_pkg::line_req_t         req,
    input  logic [AW-1:0]                 addr,
    input  logic [bds2x2_pkg::PAIR_W-1:0] wdata,
    output logic [bds2x2_pkg::PAIR_W-1:0] rdata
);

    logic [bds2x2_pkg::PAIR_W-1:0] mem [DEPTH];
    logic [bds2x2_pkg::PAIR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/box_downscale_2x2_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downscale_2x2_rgb
// 2x2 box-filter downscaler: sums each 2x2 block of RGB pixels and gives the
// truncated mean; pair sums of the even row are kept in a line memory.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  s_       | s_valid / s_ready  | frame_start, red_in, green_in, blue_in
//  m_       | m_valid / m_ready  | red_out, green_out, blue_out, frame_last
//  cfg_     | cfg_wen            | cfg_index, cfg_wdata (no read-back)
//
// One pixel per cycle while the m_ side keeps up; a result for the odd pixel on
// the odd row is registered by the line memory read, then by the output
// register. The line memory takes at most one read or one write per pixel.
// Reset restores the register defaults and clears counters, frame state and
// valids; the line memory holds no reset.
// A stalled m_ side holds the pipeline and drops s_ready once both stages fill.
// ----------------------------------------------------------------------------
module box_downscale_2x2_rgb #(
    parameter int MAX_OUT_WIDTH = bds2x2_pkg::MAX_OUT_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wen,
    input  logic [bds2x2_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bds2x2_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_frame_start,
    input  logic [bds2x2_pkg::SAMPLE_W-1:0]      s_red_in,
    input  logic [bds2x2_pkg::SAMPLE_W-1:0]      s_green_in,
    input  logic [bds2x2_pkg::SAMPLE_W-1:0]      s_blue_in,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [bds2x2_pkg::SAMPLE_W-1:0]      m_red_out,
    output logic [bds2x2_pkg::SAMPLE_W-1:0]      m_green_out,
    output logic [bds2x2_pkg::SAMPLE_W-1:0]      m_blue_out,
    output logic                                 m_frame_last
);

    localparam int AW  = $clog2(MAX_OUT_WIDTH);
    localparam int CW  = bds2x2_pkg::COUNT_W;
    localparam int CHW = bds2x2_pkg::PAIR_CH_W;
    localparam int PW  = bds2x2_pkg::PAIR_W;
    localparam int SW  = bds2x2_pkg::SAMPLE_W;
    localparam logic [13:0] MAX_W14 = 14'(MAX_OUT_WIDTH);

    // configuration
    logic [bds2x2_pkg::IN_WIDTH_W-1:0]   in_width_reg;
    logic [bds2x2_pkg::OUT_WIDTH_W-1:0]  out_width_reg;
    logic [bds2x2_pkg::OUT_HEIGHT_W-1:0] out_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_width_reg   <= bds2x2_pkg::IN_WIDTH_RST;
            out_width_reg  <= bds2x2_pkg::OUT_WIDTH_RST;
            out_height_reg <= bds2x2_pkg::OUT_HEIGHT_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                bds2x2_pkg::REG_IN_WIDTH: begin
                    in_width_reg <= cfg_wdata[bds2x2_pkg::IN_WIDTH_W-1:0];
                end
                bds2x2_pkg::REG_OUT_WIDTH: begin
                    out_width_reg <= cfg_wdata[bds2x2_pkg::OUT_WIDTH_W-1:0];
                end
                bds2x2_pkg::REG_OUT_HEIGHT: begin
                    out_height_reg <= cfg_wdata[bds2x2_pkg::OUT_HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective geometry
    logic [bds2x2_pkg::IN_WIDTH_W-1:0] stride;
    logic [13:0]                       ew_a;
    logic [13:0]                       ew_b;
    logic [CW-1:0]                     ew;
    logic [CW-1:0]                     eh;

    always_comb begin
        if (in_width_reg < bds2x2_pkg::STRIDE_MIN) begin
            stride = bds2x2_pkg::STRIDE_MIN;
        end else if (in_width_reg > bds2x2_pkg::STRIDE_MAX) begin
            stride = bds2x2_pkg::STRIDE_MAX;
        end else begin
            stride = in_width_reg;
        end
        ew_a = ({2'b00, out_width_reg} > MAX_W14) ? MAX_W14 : {2'b00, out_width_reg};
        ew_b = {2'b00, stride[12:1]};
        ew   = (ew_a > ew_b) ? ew_b[CW-1:0] : ew_a[CW-1:0];
        eh   = (out_height_reg > bds2x2_pkg::OUT_ROWS_MAX) ? bds2x2_pkg::OUT_ROWS_MAX
                                                           : out_height_reg;
    end

    // position state
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic          frame_done_reg, frame_done_next;
    logic [PW-1:0] left_reg, left_next;

    // pipeline
    logic          p1_valid_reg, p1_valid_next;
    logic [PW-1:0] p1_pair_reg;
    logic          p1_last_reg;
    logic          m_valid_reg;
    logic [SW-1:0] m_red_reg, m_green_reg, m_blue_reg;
    logic          m_last_reg;

    logic          out_free;
    logic          s_acc;
    logic [CW-1:0] col_cur, row_cur;
    logic          done_cur;
    logic [PW-1:0] left_cur;
    logic [PW-1:0] px;
    logic [PW-1:0] pair;
    logic [CW-2:0] x, y;
    logic [12:0]   x_w;
    logic          active;
    logic          last;
    logic [CW:0]   col_inc;

    bds2x2_pkg::line_req_t    mem_req;
    logic [AW-1:0]            mem_addr;
    logic [PW-1:0]            mem_rdata;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !p1_valid_reg || out_free;
    assign s_acc    = s_valid && s_ready;

    always_comb begin
        col_cur  = s_frame_start ? '0 : col_reg;
        row_cur  = s_frame_start ? '0 : row_reg;
        done_cur = s_frame_start ? 1'b0 : frame_done_reg;
        left_cur = s_frame_start ? '0 : left_reg;
        px   = {1'b0, s_blue_in, 1'b0, s_green_in, 1'b0, s_red_in};
        x    = col_cur[CW-1:1];
        y    = row_cur[CW-1:1];
        x_w  = {2'b00, x};
        for (int k = 0; k < 3; k++) begin
            pair[k*CHW +: CHW] = left_cur[k*CHW +: CHW] + px[k*CHW +: CHW];
        end
        active = !done_cur && ({1'b0, x} < ew) && ({1'b0, y} < eh);
        last   = ({1'b0, x} == ew - 12'd1) && ({1'b0, y} == eh - 12'd1);
        col_inc = {1'b0, col_cur} + 13'd1;

        mem_req.wr_en = s_acc && active && col_cur[0] && !row_cur[0];
        mem_req.rd_en = s_acc && active && col_cur[0] && row_cur[0];
        mem_addr      = x_w[AW-1:0];

        col_next        = col_reg;
        row_next        = row_reg;
        frame_done_next = frame_done_reg;
        left_next       = left_reg;
        if (s_acc) begin
            col_next        = col_cur;
            row_next        = row_cur;
            frame_done_next = done_cur;
            left_next       = left_cur;
            if (!done_cur) begin
                if (active && !col_cur[0]) begin
                    left_next = px;
                end
                if (mem_req.rd_en && last) begin
                    frame_done_next = 1'b1;
                end
                if (col_inc >= stride) begin
                    col_next = '0;
                    if (row_cur < bds2x2_pkg::ROW_MAX) begin
                        row_next = row_cur + 12'd1;
                    end
                end else begin
                    col_next = col_inc[CW-1:0];
                end
            end
        end

        p1_valid_next = p1_valid_reg && !out_free;
        if (s_acc) begin
            p1_valid_next = mem_req.rd_en;
        end
    end

    bds2x2_line_store #(
        .DEPTH (MAX_OUT_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .aclk  (aclk),
        .req   (mem_req),
        .addr  (mem_addr),
        .wdata (pair),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            frame_done_reg <= 1'b0;
            left_reg       <= '0;
            p1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            frame_done_reg <= frame_done_next;
            left_reg       <= left_next;
            p1_valid_reg   <= p1_valid_next;
            if (out_free) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_req.rd_en) begin
            p1_pair_reg <= pair;
            p1_last_reg <= last;
        end
    end

    logic [CHW:0] sum_r, sum_g, sum_b;

    assign sum_r = {1'b0, mem_rdata[0 +: CHW]}     + {1'b0, p1_pair_reg[0 +: CHW]};
    assign sum_g = {1'b0, mem_rdata[CHW +: CHW]}   + {1'b0, p1_pair_reg[CHW +: CHW]};
    assign sum_b = {1'b0, mem_rdata[2*CHW +: CHW]} + {1'b0, p1_pair_reg[2*CHW +: CHW]};

    always_ff @(posedge aclk) begin
        if (out_free && p1_valid_reg) begin
            m_red_reg   <= sum_r[CHW:2];
            m_green_reg <= sum_g[CHW:2];
            m_blue_reg  <= sum_b[CHW:2];
            m_last_reg  <= p1_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red_out    = m_red_reg;
    assign m_green_out  = m_green_reg;
    assign m_blue_out   = m_blue_reg;
    assign m_frame_last = m_last_reg;

    // checks
    a_mem_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.wr_en && mem_req.rd_en))
        else $error("line memory read and write in the same cycle");

    a_done_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && frame_done_reg && !s_frame_start) |=> !p1_valid_reg)
        else $error("result produced after end of frame");

    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !out_free) |=> (p1_valid_reg && $stable(p1_pair_reg)
                                         && $stable(mem_rdata)))
        else $error("stalled stage 1 lost its data");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2x2 RGB box downscaler. A behavioural
// predictor mirrors the counters, the even-row line of pair sums and the
// frame state. It queues the expected output pixel for each input pixel that
// closes a 2x2 block, and each output transaction is compared field by field.
// Directed tests cover the reset geometry, sample extremes and truncation,
// clamped strides, ignored rows and columns, zero sizes and a mid-frame
// height change. Random frames and the opening of a 4096-pixel line follow.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SW            = bds2x2_pkg::SAMPLE_W;
    localparam int DW            = bds2x2_pkg::CFG_DATA_W;
    localparam int MAX_OUT_WIDTH = bds2x2_pkg::MAX_OUT_WIDTH_DEF;
    localparam int RESET_CYCLES  = 9;
    localparam int FLUSH_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 880;
    localparam int WIDE_ITEMS    = 96;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic [SW-1:0] red;
        logic [SW-1:0] green;
        logic [SW-1:0] blue;
        logic          last;
    } mean_pixel_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_wen;
    logic [bds2x2_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [DW-1:0]                      cfg_wdata;
    logic                               s_valid;
    logic                               s_ready;
    logic                               s_frame_start;
    logic [SW-1:0]                      s_red_in;
    logic [SW-1:0]                      s_green_in;
    logic [SW-1:0]                      s_blue_in;
    logic                               m_valid;
    logic                               m_ready;
    logic [SW-1:0]                      m_red_out;
    logic [SW-1:0]                      m_green_out;
    logic [SW-1:0]                      m_blue_out;
    logic                               m_frame_last;

    // predictor state
    logic [bds2x2_pkg::IN_WIDTH_W-1:0]   cur_in_width   = bds2x2_pkg::IN_WIDTH_RST;
    logic [bds2x2_pkg::OUT_WIDTH_W-1:0]  cur_out_width  = bds2x2_pkg::OUT_WIDTH_RST;
    logic [bds2x2_pkg::OUT_HEIGHT_W-1:0] cur_out_height = bds2x2_pkg::OUT_HEIGHT_RST;
    logic [bds2x2_pkg::PAIR_W-1:0]       pair_line [MAX_OUT_WIDTH];
    logic [bds2x2_pkg::PAIR_W-1:0]       left_pair      = '0;
    logic [bds2x2_pkg::COUNT_W-1:0]      col_pos        = '0;
    logic [bds2x2_pkg::COUNT_W-1:0]      row_pos        = '0;
    logic                                frame_closed   = 1'b0;

    mean_pixel_t pending_means [$];
    mean_pixel_t head_mean;

    bit          idle_on      = 1'b1;
    int unsigned ready_hold   = 0;
    int unsigned cycle_count  = 0;
    int unsigned pixels_sent  = 0;
    int unsigned means_checked = 0;
    int unsigned writes_done  = 0;
    int unsigned mismatches   = 0;

    box_downscale_2x2_rgb #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_start (s_frame_start),
        .s_red_in      (s_red_in),
        .s_green_in    (s_green_in),
        .s_blue_in     (s_blue_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_out     (m_red_out),
        .m_green_out   (m_green_out),
        .m_blue_out    (m_blue_out),
        .m_frame_last  (m_frame_last)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d output pixels still due",
                     $time, pending_means.size());
            $display("box_downscale_2x2_rgb test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int active_stride();
        int s;
        s = cur_in_width;
        if (s < bds2x2_pkg::STRIDE_MIN) s = bds2x2_pkg::STRIDE_MIN;
        if (s > bds2x2_pkg::STRIDE_MAX) s = bds2x2_pkg::STRIDE_MAX;
        return s;
    endfunction

    function automatic int active_width();
        int w;
        w = cur_out_width;
        if (w > MAX_OUT_WIDTH) w = MAX_OUT_WIDTH;
        if (w > active_stride() / 2) w = active_stride() / 2;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = cur_out_height;
        if (h > bds2x2_pkg::OUT_ROWS_MAX) h = bds2x2_pkg::OUT_ROWS_MAX;
        return h;
    endfunction

    function automatic logic [SW-1:0] mean_of_four(
        input logic [bds2x2_pkg::PAIR_CH_W-1:0] upper,
        input logic [bds2x2_pkg::PAIR_CH_W-1:0] lower);
        return SW'((10'(upper) + 10'(lower)) >> 2);
    endfunction

    task automatic predict_block_mean(input logic fs, input logic [SW-1:0] r,
                                      input logic [SW-1:0] g,
                                      input logic [SW-1:0] b);
        int                            stride;
        int                            act_w;
        int                            act_h;
        int                            bx;
        int                            by;
        logic [bds2x2_pkg::PAIR_W-1:0] px;
        logic [bds2x2_pkg::PAIR_W-1:0] pair;
        logic [bds2x2_pkg::PAIR_W-1:0] above;
        mean_pixel_t                   res;
        if (fs) begin
            col_pos      = '0;
            row_pos      = '0;
            frame_closed = 1'b0;
            left_pair    = '0;
        end
        if (frame_closed) return;
        stride = active_stride();
        act_w  = active_width();
        act_h  = active_height();
        bx     = col_pos >> 1;
        by     = row_pos >> 1;
        px     = {1'b0, b, 1'b0, g, 1'b0, r};
        if (bx < act_w && by < act_h) begin
            if (!col_pos[0]) begin
                left_pair = px;
            end else begin
                pair[8:0]   = left_pair[8:0]   + px[8:0];
                pair[17:9]  = left_pair[17:9]  + px[17:9];
                pair[26:18] = left_pair[26:18] + px[26:18];
                if (!row_pos[0]) begin
                    pair_line[bx] = pair;
                end else begin
                    above     = pair_line[bx];
                    res.red   = mean_of_four(above[8:0], pair[8:0]);
                    res.green = mean_of_four(above[17:9], pair[17:9]);
                    res.blue  = mean_of_four(above[26:18], pair[26:18]);
                    res.last  = (bx == act_w - 1) && (by == act_h - 1);
                    pending_means.push_back(res);
                    if (res.last) frame_closed = 1'b1;
                end
            end
        end
        if (int'(col_pos) + 1 >= stride) begin
            col_pos = '0;
            if (row_pos < bds2x2_pkg::ROW_MAX) row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    function automatic logic [SW-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SW'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic fs, input logic [SW-1:0] r,
                              input logic [SW-1:0] g,
                              input logic [SW-1:0] b);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_frame_start <= fs;
        s_red_in      <= r;
        s_green_in    <= g;
        s_blue_in     <= b;
        do @(posedge aclk); while (!s_ready);
        predict_block_mean(fs, r, g, b);
        pixels_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (FLUSH_CYCLES) @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [DW-1:0] in_w,
                                input logic [DW-1:0] out_w,
                                input logic [DW-1:0] out_h);
        settle();
        cfg_wen   <= 1'b1;
        cfg_index <= bds2x2_pkg::REG_IN_WIDTH;
        cfg_wdata <= in_w;
        @(posedge aclk);
        cfg_index <= bds2x2_pkg::REG_OUT_WIDTH;
        cfg_wdata <= out_w;
        @(posedge aclk);
        cfg_index <= bds2x2_pkg::REG_OUT_HEIGHT;
        cfg_wdata <= out_h;
        @(posedge aclk);
        cfg_wen        <= 1'b0;
        cur_in_width   = in_w;
        cur_out_width  = out_w[bds2x2_pkg::OUT_WIDTH_W-1:0];
        cur_out_height = out_h[bds2x2_pkg::OUT_HEIGHT_W-1:0];
        writes_done   += 3;
    endtask

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            ready_hold = idle_on ? $urandom_range(0, 3) : 0;
        if (ready_hold != 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // output checking
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [SW-1:0] want,
                                 input logic [SW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_means.size() == 0) begin
                $display("%0t: unexpected output pixel r %0d g %0d b %0d last %0b",
                         $time, m_red_out, m_green_out, m_blue_out, m_frame_last);
                mismatches++;
            end else begin
                head_mean = pending_means.pop_front();
                compare_field("red", head_mean.red, m_red_out);
                compare_field("green", head_mean.green, m_green_out);
                compare_field("blue", head_mean.blue, m_blue_out);
                compare_field("frame_last", SW'(head_mean.last),
                              SW'(m_frame_last));
            end
            means_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_geometry();
        // 640 stride after reset: one even row, then the first pair of row 1
        for (int k = 0; k < 642; k++)
            send_pixel(1'b0, draw_sample(), draw_sample(), draw_sample());
    endtask

    task automatic test_sample_extremes();
        set_geometry(13'd4, 13'd2, 13'd1);
        send_pixel(1'b1, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd3, 8'd255, 8'd1);
        send_pixel(1'b0, 8'd0, 8'd255, 8'd2);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd0, 8'd255, 8'd3);
        send_pixel(1'b0, 8'd0, 8'd254, 8'd4);
        // frame finished, this one is dropped
        send_pixel(1'b0, 8'd77, 8'd0, 8'd128);
    endtask

    task automatic test_stride_floor();
        set_geometry(13'd1, 13'd1, 13'd1);
        for (int k = 0; k < 4; k++)
            send_pixel(k == 0, draw_sample(), draw_sample(), draw_sample());
    endtask

    task automatic test_ignored_edges();
        // odd stride of 5 with one output column: columns 2..4 are dropped
        set_geometry(13'd5, 13'd1, 13'd2);
        for (int k = 0; k < 10; k++)
            send_pixel(k == 0, draw_sample(), draw_sample(), draw_sample());
        // height cut mid-frame, row 2 now lies beyond the frame
        set_geometry(13'd5, 13'd1, 13'd1);
        for (int k = 0; k < 3; k++)
            send_pixel(1'b0, draw_sample(), draw_sample(), draw_sample());
    endtask

    task automatic test_empty_geometry();
        set_geometry(13'd4, 13'd0, 13'd1);
        for (int k = 0; k < 4; k++)
            send_pixel(k == 0, draw_sample(), draw_sample(), draw_sample());
        set_geometry(13'd4, 13'd2, 13'd0);
        for (int k = 0; k < 4; k++)
            send_pixel(k == 0, draw_sample(), draw_sample(), draw_sample());
    endtask

    task automatic test_random_frames();
        int unsigned   start;
        int unsigned   frame_len;
        int unsigned   n;
        int unsigned   frames;
        int unsigned   shape;
        int            stride;
        logic [DW-1:0] in_w;
        logic [DW-1:0] out_w;
        logic [DW-1:0] out_h;
        logic          fs;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 11))
                0:       in_w = DW'($urandom_range(0, 1));
                1:       in_w = DW'($urandom_range(4096, 8191));
                default: in_w = DW'($urandom_range(2, 24));
            endcase
            stride = (in_w < bds2x2_pkg::STRIDE_MIN) ? bds2x2_pkg::STRIDE_MIN :
                     (in_w > bds2x2_pkg::STRIDE_MAX) ? bds2x2_pkg::STRIDE_MAX : in_w;
            case ($urandom_range(0, 9))
                0:       out_w = '0;
                1:       out_w = DW'($urandom_range(0, 8191));
                default: out_w = DW'($urandom_range(1, (stride < 24) ? stride / 2 : 12));
            endcase
            case ($urandom_range(0, 9))
                0:       out_h = '0;
                1:       out_h = DW'($urandom_range(2048, 8191));
                2:       out_h = DW'($urandom_range(5, 8));
                default: out_h = DW'($urandom_range(1, 4));
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            set_geometry(in_w, out_w, out_h);
            frame_len = 2 * active_height() * active_stride();
            if (active_width() == 0 || frame_len == 0 || frame_len > 600)
                frame_len = $urandom_range(8, 300);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                shape = $urandom_range(0, 9);
                n = frame_len;
                if (shape == 0)
                    n = $urandom_range(1, frame_len);
                else if (shape == 1)
                    n = frame_len + $urandom_range(1, 6);
                for (int k = 0; k < n && pixels_sent - start < RANDOM_ITEMS; k++) begin
                    fs = (k == 0) && (f == 0 || shape != 2);
                    if (shape == 3 && k != 0 && $urandom_range(0, 29) == 0)
                        fs = 1'b1;
                    send_pixel(fs, draw_sample(), draw_sample(), draw_sample());
                end
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_widest_line();
        // stride and width both clamp: opening columns of a 4096-pixel row
        idle_on = 1'b0;
        set_geometry(13'h1FFF, 13'h1FFF, 13'h1001);
        for (int k = 0; k < WIDE_ITEMS; k++)
            send_pixel(k == 0, draw_sample(), draw_sample(), draw_sample());
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_index     = bds2x2_pkg::REG_IN_WIDTH;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_frame_start = 1'b0;
        s_red_in      = '0;
        s_green_in    = '0;
        s_blue_in     = '0;
        m_ready       = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_geometry();
        test_sample_extremes();
        test_stride_floor();
        test_ignored_edges();
        test_empty_geometry();
        test_random_frames();
        test_widest_line();
        settle();

        $display("%0d pixels sent, %0d output pixels compared, %0d register writes",
                 pixels_sent, means_checked, writes_done);
        $display("reset, clamped and empty geometries, dropped edges, random frames, wide row");
        if (mismatches == 0) begin
            $display("box_downscale_2x2_rgb test passed");
        end else begin
            $display("box_downscale_2x2_rgb test failed");
        end
        $finish;
    end

endmodule
